@@ rtl/dcrf_pkg.sv @@
// Shared constants for the drive command ramp framer.
`default_nettype none

package dcrf_pkg;

    // Input item kinds carried in the slave-side tuser.
    localparam logic [1:0] MODE_TICK      = 2'd0;
    localparam logic [1:0] MODE_SET_SPEED = 2'd1;
    localparam logic [1:0] MODE_SET_STEER = 2'd2;
    localparam logic [1:0] MODE_SET_BOTH  = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] REG_SPEED_RISE = 2'd0;
    localparam logic [1:0] REG_SPEED_FALL = 2'd1;
    localparam logic [1:0] REG_STEER_RISE = 2'd2;
    localparam logic [1:0] REG_STEER_FALL = 2'd3;

    // Direction codes of the drive frame.
    localparam logic [7:0] DIR_FORWARD = 8'h82;
    localparam logic [7:0] DIR_REVERSE = 8'h02;
    localparam logic [7:0] DIR_STOP    = 8'h00;

    // Command limits and widths of the whole-unit targets.
    localparam int SPEED_LIMIT       = 16000;
    localparam int STEER_LEFT_LIMIT  = 25;
    localparam int STEER_RIGHT_LIMIT = -24;
    localparam int STEER_CENTER      = 90;
    localparam int SPEED_TGT_W       = 15;
    localparam int STEER_TGT_W       = 6;

    // Field widths.
    localparam int SPEED_STEP_W = 16;
    localparam int STEER_STEP_W = 13;
    localparam int SPEED_CMD_W  = 16;
    localparam int STEER_CMD_W  = 8;
    localparam int MAG_W        = 14;
    localparam int STEER_BYTE_W = 7;

    // Reset values of the step registers.
    localparam logic [SPEED_STEP_W-1:0] SPEED_STEP_RESET = 16'd51;
    localparam logic [STEER_STEP_W-1:0] STEER_STEP_RESET = 13'd5;

endpackage

`default_nettype wire

@@ rtl/dcrf_ramp.sv @@
// Slew step of one fixed-point value toward its target, without overshoot.
`default_nettype none

module dcrf_ramp
#(
    parameter int VAL_W  = 23,
    parameter int STEP_W = 16
)
(
    input  logic signed [VAL_W-1:0]  now,
    input  logic signed [VAL_W-1:0]  target,
    input  logic        [STEP_W-1:0] rise,
    input  logic        [STEP_W-1:0] fall,
    output logic signed [VAL_W-1:0]  next_val
);

    // Wide enough that a step past either end never wraps.
    localparam int AW = ((VAL_W > STEP_W) ? VAL_W : STEP_W) + 2;

    logic signed [AW-1:0] now_ext;
    logic signed [AW-1:0] tgt_ext;
    logic signed [AW-1:0] up;
    logic signed [AW-1:0] down;

    assign now_ext = AW'(now);
    assign tgt_ext = AW'(target);
    assign up      = now_ext + signed'({{(AW-STEP_W){1'b0}}, rise});
    assign down    = now_ext - signed'({{(AW-STEP_W){1'b0}}, fall});

    always_comb
    begin
        next_val = now;
        if (now > target)
        begin
            next_val = (down < tgt_ext) ? target : down[VAL_W-1:0];
        end
        else if (now < target)
        begin
            next_val = (up > tgt_ext) ? target : up[VAL_W-1:0];
        end
    end

endmodule

`default_nettype wire

@@ rtl/drive_command_ramp_framer.sv @@
// Top level of the drive command ramp framer.
`default_nettype none

// Drive command ramp framer. Requests on the slave stream either set the speed
// target (saturated to plus or minus 16000 rpm), the steering target
// (saturated to -24..25 degrees), or both, or are ticks. On each tick the
// current speed and steering angle, kept in signed fixed point with
// FRACTION_BITS fraction bits, move toward their targets by the configured
// rise or fall step and land exactly on the target rather than pass it. Every
// tick produces one drive frame on the master stream; command requests
// produce nothing. The block takes one request per clock cycle: a request
// sits in an input register while the ramp adders and the frame logic work
// on it, and a tick's frame is then loaded into the output register, where
// it waits until the master side takes it. Throughput drops below one
// request per cycle only while the master side withholds tready.
// The step registers may be written only while no request is in flight.
module drive_command_ramp_framer
#(
    parameter int FRACTION_BITS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [15:0] speed_command, [23:16] steer_command
    input  logic [23:0] s_axis_tdata,
    // [1:0] mode
    input  logic [1:0]  s_axis_tuser,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] drive_byte, [21:8] speed_magnitude, [28:22] steer_byte,
    // [31:29] zero
    output logic [31:0] m_axis_tdata,

    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    import dcrf_pkg::*;

    localparam int SPEED_W = SPEED_TGT_W + FRACTION_BITS;
    localparam int STEER_W = STEER_TGT_W + FRACTION_BITS;

    localparam logic signed [SPEED_CMD_W-1:0] SPD_HI = SPEED_CMD_W'(SPEED_LIMIT);
    localparam logic signed [SPEED_CMD_W-1:0] SPD_LO = SPEED_CMD_W'(-SPEED_LIMIT);
    localparam logic signed [STEER_CMD_W-1:0] STR_HI = STEER_CMD_W'(STEER_LEFT_LIMIT);
    localparam logic signed [STEER_CMD_W-1:0] STR_LO = STEER_CMD_W'(STEER_RIGHT_LIMIT);

    // Step registers.
    logic [SPEED_STEP_W-1:0] speed_rise_reg;
    logic [SPEED_STEP_W-1:0] speed_fall_reg;
    logic [STEER_STEP_W-1:0] steer_rise_reg;
    logic [STEER_STEP_W-1:0] steer_fall_reg;

    // Ramp state.
    logic signed [SPEED_W-1:0]     speed_now_reg;
    logic signed [SPEED_W-1:0]     speed_now_next;
    logic signed [SPEED_TGT_W-1:0] speed_target_reg;
    logic signed [STEER_W-1:0]     steer_now_reg;
    logic signed [STEER_W-1:0]     steer_now_next;
    logic signed [STEER_TGT_W-1:0] steer_target_reg;

    // Input register.
    logic                          in_valid_reg;
    logic [1:0]                    in_mode_reg;
    logic signed [SPEED_CMD_W-1:0] in_speed_reg;
    logic signed [STEER_CMD_W-1:0] in_steer_reg;

    // Output register.
    logic                     out_valid_reg;
    logic [7:0]               out_drive_reg;
    logic [MAG_W-1:0]         out_mag_reg;
    logic [STEER_BYTE_W-1:0]  out_steer_reg;

    logic in_is_tick;
    logic out_free;
    logic in_retire;
    logic take_in;

    logic signed [SPEED_W-1:0]     speed_tgt_fx;
    logic signed [STEER_W-1:0]     steer_tgt_fx;
    logic signed [SPEED_CMD_W-1:0] speed_clamped;
    logic signed [STEER_CMD_W-1:0] steer_clamped;

    logic [SPEED_W-1:0]      speed_abs;
    logic [STEER_W-1:0]      steer_abs;
    logic [STEER_TGT_W-1:0]  steer_whole;
    logic [7:0]              drive_next;
    logic [MAG_W-1:0]        mag_next;
    logic [STEER_BYTE_W-1:0] steer_byte_next;

    // The request in the input register leaves when it is a command, or when
    // the output register is empty or being emptied this cycle.
    assign in_is_tick    = (in_mode_reg == MODE_TICK);
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign in_retire     = in_valid_reg && (!in_is_tick || out_free);
    assign s_axis_tready = !in_valid_reg || in_retire;
    assign take_in       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= take_in || (in_valid_reg && !in_retire);
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_mode_reg  <= s_axis_tuser;
            in_speed_reg <= signed'(s_axis_tdata[15:0]);
            in_steer_reg <= signed'(s_axis_tdata[23:16]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_rise_reg <= SPEED_STEP_RESET;
            speed_fall_reg <= SPEED_STEP_RESET;
            steer_rise_reg <= STEER_STEP_RESET;
            steer_fall_reg <= STEER_STEP_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_SPEED_RISE: speed_rise_reg <= cfg_data;
                REG_SPEED_FALL: speed_fall_reg <= cfg_data;
                REG_STEER_RISE: steer_rise_reg <= cfg_data[STEER_STEP_W-1:0];
                REG_STEER_FALL: steer_fall_reg <= cfg_data[STEER_STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // Saturate incoming targets to the allowed ranges.
    always_comb
    begin
        speed_clamped = in_speed_reg;
        if (in_speed_reg > SPD_HI)
        begin
            speed_clamped = SPD_HI;
        end
        else if (in_speed_reg < SPD_LO)
        begin
            speed_clamped = SPD_LO;
        end

        steer_clamped = in_steer_reg;
        if (in_steer_reg > STR_HI)
        begin
            steer_clamped = STR_HI;
        end
        else if (in_steer_reg < STR_LO)
        begin
            steer_clamped = STR_LO;
        end
    end

    // Targets scaled into the fixed-point format of the ramped values.
    assign speed_tgt_fx = signed'({speed_target_reg, {FRACTION_BITS{1'b0}}});
    assign steer_tgt_fx = signed'({steer_target_reg, {FRACTION_BITS{1'b0}}});

    dcrf_ramp
    #(
        .VAL_W  (SPEED_W),
        .STEP_W (SPEED_STEP_W)
    )
    u_speed_ramp
    (
        .now      (speed_now_reg),
        .target   (speed_tgt_fx),
        .rise     (speed_rise_reg),
        .fall     (speed_fall_reg),
        .next_val (speed_now_next)
    );

    dcrf_ramp
    #(
        .VAL_W  (STEER_W),
        .STEP_W (STEER_STEP_W)
    )
    u_steer_ramp
    (
        .now      (steer_now_reg),
        .target   (steer_tgt_fx),
        .rise     (steer_rise_reg),
        .fall     (steer_fall_reg),
        .next_val (steer_now_next)
    );

    // Frame fields from the freshly ramped values. Both magnitudes are
    // truncated toward zero, and the direction byte follows the sign of the
    // full fixed-point speed, so a speed under one rpm still shows a direction.
    always_comb
    begin
        speed_abs   = speed_now_next[SPEED_W-1] ? SPEED_W'(-speed_now_next)
                                                : SPEED_W'(speed_now_next);
        steer_abs   = steer_now_next[STEER_W-1] ? STEER_W'(-steer_now_next)
                                                : STEER_W'(steer_now_next);
        mag_next    = speed_abs[FRACTION_BITS +: MAG_W];
        steer_whole = steer_abs[STEER_W-1:FRACTION_BITS];

        if (steer_now_next[STEER_W-1])
        begin
            steer_byte_next = STEER_BYTE_W'(STEER_CENTER) - STEER_BYTE_W'(steer_whole);
        end
        else
        begin
            steer_byte_next = STEER_BYTE_W'(STEER_CENTER) + STEER_BYTE_W'(steer_whole);
        end

        if (speed_now_next[SPEED_W-1])
        begin
            drive_next = DIR_REVERSE;
        end
        else if (speed_now_next != '0)
        begin
            drive_next = DIR_FORWARD;
        end
        else
        begin
            drive_next = DIR_STOP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_now_reg    <= '0;
            steer_now_reg    <= '0;
            speed_target_reg <= '0;
            steer_target_reg <= '0;
        end
        else if (in_retire)
        begin
            if (in_is_tick)
            begin
                speed_now_reg <= speed_now_next;
                steer_now_reg <= steer_now_next;
            end
            if (in_mode_reg == MODE_SET_SPEED || in_mode_reg == MODE_SET_BOTH)
            begin
                speed_target_reg <= speed_clamped[SPEED_TGT_W-1:0];
            end
            if (in_mode_reg == MODE_SET_STEER || in_mode_reg == MODE_SET_BOTH)
            begin
                steer_target_reg <= steer_clamped[STEER_TGT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_retire && in_is_tick)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_retire && in_is_tick)
        begin
            out_drive_reg <= drive_next;
            out_mag_reg   <= mag_next;
            out_steer_reg <= steer_byte_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_steer_reg, out_mag_reg, out_drive_reg};

`ifndef SYNTHESIS
    localparam logic signed [SPEED_W-1:0] SPD_FX_HI =
        signed'({SPEED_TGT_W'(SPEED_LIMIT), {FRACTION_BITS{1'b0}}});
    localparam logic signed [SPEED_W-1:0] SPD_FX_LO =
        signed'({SPEED_TGT_W'(-SPEED_LIMIT), {FRACTION_BITS{1'b0}}});
    localparam logic signed [STEER_W-1:0] STR_FX_HI =
        signed'({STEER_TGT_W'(STEER_LEFT_LIMIT), {FRACTION_BITS{1'b0}}});
    localparam logic signed [STEER_W-1:0] STR_FX_LO =
        signed'({STEER_TGT_W'(STEER_RIGHT_LIMIT), {FRACTION_BITS{1'b0}}});

    // Ramping never carries the speed beyond the saturated target range.
    a_speed_range : assert property (@(posedge clk) disable iff (!rst_n)
        speed_now_reg <= SPD_FX_HI && speed_now_reg >= SPD_FX_LO)
        else $error("ramped speed outside the command range");

    // Ramping never carries the steering angle beyond its limits.
    a_steer_range : assert property (@(posedge clk) disable iff (!rst_n)
        steer_now_reg <= STR_FX_HI && steer_now_reg >= STR_FX_LO)
        else $error("ramped steering angle outside its limits");

    // A stopped frame carries no speed.
    a_stop_zero : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[7:0] == DIR_STOP |-> m_axis_tdata[21:8] == '0)
        else $error("stop frame with non-zero speed");

    // A command request retiring never creates a frame.
    a_cmd_no_frame : assert property (@(posedge clk) disable iff (!rst_n)
        in_retire && !in_is_tick && !out_valid_reg |=> !out_valid_reg)
        else $error("frame produced by a command request");

    // The ramped values only change when a tick retires.
    a_state_on_tick : assert property (@(posedge clk) disable iff (!rst_n)
        !(in_retire && in_is_tick) |=> $stable(speed_now_reg) && $stable(steer_now_reg))
        else $error("ramp state changed without a tick");
`endif

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the drive command ramp framer.

// The bench drives command and tick requests into the slave stream and checks
// every drive frame on the master stream against its own model of the ramps.
// The model keeps the speed and steering angle in Q8 fixed point, steps them
// toward the saturated targets by the rise and fall steps held in a copy of
// the step registers, and builds the expected frame for each tick. A queue
// of pending requests feeds the sending process, and a separate receiving
// process stalls at random and checks each frame against the oldest entry
// in the queue of expected frames.
module testbench;
    import dcrf_pkg::*;

    localparam int CLK_PERIOD    = 20;
    localparam int FRAC_BITS     = 8;
    localparam int MAX_GAP       = 14;
    localparam int LONG_HOLD     = 200;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASES        = 12;
    localparam int PHASE_ITEMS   = 148;
    localparam int MAX_SHOWN     = 10;

    typedef struct {
        logic [1:0]  mode;
        logic [15:0] speed_cmd;
        logic [7:0]  steer_cmd;
    } drive_req_t;

    typedef struct {
        logic [7:0]              drive_byte;
        logic [MAG_W-1:0]        speed_mag;
        logic [STEER_BYTE_W-1:0] steer_byte;
    } drive_frame_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = MODE_TICK;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        cfg_write     = 1'b0;
    logic [1:0]  cfg_index     = REG_SPEED_RISE;
    logic [15:0] cfg_data      = '0;

    // Copy of the step registers, kept in step with every configuration write.
    logic [SPEED_STEP_W-1:0] speed_up_q8   = SPEED_STEP_RESET;
    logic [SPEED_STEP_W-1:0] speed_down_q8 = SPEED_STEP_RESET;
    logic [STEER_STEP_W-1:0] steer_up_q8   = STEER_STEP_RESET;
    logic [STEER_STEP_W-1:0] steer_down_q8 = STEER_STEP_RESET;

    // Ramp state as the block should hold it.
    logic signed [22:0]            speed_q8       = '0;
    logic signed [SPEED_TGT_W-1:0] speed_goal_rpm = '0;
    logic signed [13:0]            steer_q8       = '0;
    logic signed [STEER_TGT_W-1:0] steer_goal_deg = '0;

    drive_req_t   pending_requests[$];
    drive_frame_t expected_frames[$];

    int requests_sent  = 0;
    int ticks_sent     = 0;
    int frames_checked = 0;
    int settings_used  = 0;
    int error_count    = 0;
    int errors_shown   = 0;

    // Idling controls. The gap maxima are set per phase; a hold request asks the
    // receiver for one long stall, which it counts out on its own.
    int send_gap_max = MAX_GAP;
    int recv_gap_max = MAX_GAP;
    int send_wait    = 0;
    int recv_wait    = 0;
    int hold_asks    = 0;
    int hold_served  = 0;

    drive_req_t offered;

    drive_command_ramp_framer
    #(
        .FRACTION_BITS (FRAC_BITS)
    )
    u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // One ramp step: move by the rise or fall step and stop on the target.
    function automatic int slew(input int cur, input int goal, input int up, input int down);
        int nxt;
        nxt = cur;
        if (cur > goal)
        begin
            nxt = cur - down;
            if (nxt < goal)
                nxt = goal;
        end
        else if (cur < goal)
        begin
            nxt = cur + up;
            if (nxt > goal)
                nxt = goal;
        end
        return nxt;
    endfunction

    // Applies one accepted request to the ramp state. Commands only move the
    // targets; a tick steps both ramps and queues the frame it should produce.
    function automatic void predict_request(input drive_req_t req);
        int           speed_cmd;
        int           steer_cmd;
        int           speed_next;
        int           steer_next;
        int           steer_whole;
        int           speed_abs;
        drive_frame_t frame;
        speed_cmd = int'($signed(req.speed_cmd));
        steer_cmd = int'($signed(req.steer_cmd));
        if (req.mode != MODE_TICK)
        begin
            if (req.mode == MODE_SET_SPEED || req.mode == MODE_SET_BOTH)
            begin
                if (speed_cmd > SPEED_LIMIT)
                    speed_cmd = SPEED_LIMIT;
                else if (speed_cmd < -SPEED_LIMIT)
                    speed_cmd = -SPEED_LIMIT;
                speed_goal_rpm = speed_cmd[SPEED_TGT_W-1:0];
            end
            if (req.mode == MODE_SET_STEER || req.mode == MODE_SET_BOTH)
            begin
                if (steer_cmd > STEER_LEFT_LIMIT)
                    steer_cmd = STEER_LEFT_LIMIT;
                else if (steer_cmd < STEER_RIGHT_LIMIT)
                    steer_cmd = STEER_RIGHT_LIMIT;
                steer_goal_deg = steer_cmd[STEER_TGT_W-1:0];
            end
            return;
        end

        speed_next = slew(int'(speed_q8), int'(speed_goal_rpm) * (1 << FRAC_BITS),
                          int'(speed_up_q8), int'(speed_down_q8));
        steer_next = slew(int'(steer_q8), int'(steer_goal_deg) * (1 << FRAC_BITS),
                          int'(steer_up_q8), int'(steer_down_q8));
        speed_q8 = speed_next[22:0];
        steer_q8 = steer_next[13:0];

        // The direction follows the full fixed-point value, so a speed under
        // one rpm still reports a direction with a zero magnitude.
        if (speed_next > 0)
            frame.drive_byte = DIR_FORWARD;
        else if (speed_next < 0)
            frame.drive_byte = DIR_REVERSE;
        else
            frame.drive_byte = DIR_STOP;
        speed_abs = (speed_next < 0) ? -speed_next : speed_next;
        speed_abs = speed_abs >> FRAC_BITS;
        frame.speed_mag = speed_abs[MAG_W-1:0];

        // The angle is truncated toward zero before the centre offset is added.
        if (steer_next < 0)
            steer_whole = -((-steer_next) >> FRAC_BITS);
        else
            steer_whole = steer_next >> FRAC_BITS;
        steer_whole = steer_whole + STEER_CENTER;
        frame.steer_byte = steer_whole[STEER_BYTE_W-1:0];

        expected_frames.push_back(frame);
        ticks_sent++;
    endfunction

    // Sending side: presents one request at a time and draws an idle gap for
    // each. The valid line is assigned once per edge so that back-to-back
    // requests keep it high.
    always @(posedge clk or negedge rst_n)
    begin : sender
        logic next_valid;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            next_valid = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_request(offered);
                requests_sent++;
                next_valid = 1'b0;
            end
            if (!next_valid)
            begin
                if (send_wait > 0)
                begin
                    send_wait--;
                end
                else if (pending_requests.size() > 0)
                begin
                    offered = pending_requests.pop_front();
                    s_axis_tdata <= {offered.steer_cmd, offered.speed_cmd};
                    s_axis_tuser <= offered.mode;
                    next_valid = 1'b1;
                    send_wait = $urandom_range(0, send_gap_max);
                end
            end
            s_axis_tvalid <= next_valid;
        end
    end

    // Receiving side: checks each frame against the oldest expectation, then
    // stalls for a drawn number of cycles, or for the long hold when asked.
    always @(posedge clk or negedge rst_n)
    begin : receiver
        drive_frame_t want;
        drive_frame_t got;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.drive_byte = m_axis_tdata[7:0];
                got.speed_mag  = m_axis_tdata[21:8];
                got.steer_byte = m_axis_tdata[28:22];
                frames_checked++;
                if (expected_frames.size() == 0)
                begin
                    error_count++;
                    if (errors_shown < MAX_SHOWN)
                    begin
                        errors_shown++;
                        $display("%0t: frame with no tick waiting: drive %h speed %0d steer %0d",
                                 $realtime, got.drive_byte, got.speed_mag, got.steer_byte);
                    end
                end
                else
                begin
                    want = expected_frames.pop_front();
                    if (got.drive_byte !== want.drive_byte || got.speed_mag !== want.speed_mag
                        || got.steer_byte !== want.steer_byte)
                    begin
                        error_count++;
                        if (errors_shown < MAX_SHOWN)
                        begin
                            errors_shown++;
                            $display("%0t: frame mismatch: expected drive %h speed %0d steer %0d",
                                     $realtime, want.drive_byte, want.speed_mag, want.steer_byte);
                            $display("%0t:                 actual   drive %h speed %0d steer %0d",
                                     $realtime, got.drive_byte, got.speed_mag, got.steer_byte);
                        end
                    end
                end
                recv_wait = $urandom_range(0, recv_gap_max);
            end
            if (hold_served != hold_asks)
            begin
                hold_served = hold_asks;
                recv_wait = LONG_HOLD;
            end
            if (recv_wait > 0)
            begin
                recv_wait--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic queue_request(input logic [1:0] mode, input int speed, input int steer);
        drive_req_t req;
        req.mode      = mode;
        req.speed_cmd = speed[15:0];
        req.steer_cmd = steer[7:0];
        pending_requests.push_back(req);
    endtask

    // Random request: mostly ticks, with targets drawn from the full field, the
    // legal range, the saturation edges, or a narrow band that ramps reach.
    function automatic drive_req_t random_request();
        drive_req_t req;
        int         pick;
        int         speed;
        int         steer;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            req.mode = MODE_TICK;
        else if (pick < 72)
            req.mode = MODE_SET_SPEED;
        else if (pick < 88)
            req.mode = MODE_SET_STEER;
        else
            req.mode = MODE_SET_BOTH;
        case ($urandom_range(0, 3))
            0:       speed = $urandom_range(0, 65535);
            1:       speed = $urandom_range(0, 2 * SPEED_LIMIT) - SPEED_LIMIT;
            2:       speed = ($urandom_range(0, 1) ? 1 : -1) * (SPEED_LIMIT - 1 + $urandom_range(0, 2));
            default: speed = $urandom_range(0, 100) - 50;
        endcase
        case ($urandom_range(0, 2))
            0:       steer = $urandom_range(0, 255);
            1:       steer = int'($urandom_range(0, STEER_LEFT_LIMIT - STEER_RIGHT_LIMIT + 4))
                             + STEER_RIGHT_LIMIT - 2;
            default: steer = $urandom_range(0, 12) - 6;
        endcase
        req.speed_cmd = speed[15:0];
        req.steer_cmd = steer[7:0];
        return req;
    endfunction

    function automatic int random_step(input int top);
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return top;
            2:       return $urandom_range(0, top);
            default: return $urandom_range(1, top / 64);
        endcase
    endfunction

    // Presents one register write; the copy is updated at once since writes
    // only happen while nothing is in flight.
    task automatic write_reg(input logic [1:0] idx, input int value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[15:0];
        case (idx)
            REG_SPEED_RISE: speed_up_q8   = value[SPEED_STEP_W-1:0];
            REG_SPEED_FALL: speed_down_q8 = value[SPEED_STEP_W-1:0];
            REG_STEER_RISE: steer_up_q8   = value[STEER_STEP_W-1:0];
            REG_STEER_FALL: steer_down_q8 = value[STEER_STEP_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_steps(input int speed_up, input int speed_down,
                               input int steer_up, input int steer_down);
        write_reg(REG_SPEED_RISE, speed_up);
        write_reg(REG_SPEED_FALL, speed_down);
        write_reg(REG_STEER_RISE, steer_up);
        write_reg(REG_STEER_FALL, steer_down);
        @(posedge clk);
        cfg_write <= 1'b0;
        settings_used++;
    endtask

    // Waits, sampling between edges, until every request has been taken and
    // every frame has arrived, then lets the pipeline settle. Command requests
    // produce no frame, so the settling time covers any still in the block.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_requests.size() != 0 || s_axis_tvalid || expected_frames.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        settings_used = 1;

        // Directed requests at the reset steps. The first ticks after a one
        // rpm target give a forward direction with zero magnitude, and the
        // speed then lands exactly on its target. Unselected and tick fields
        // carry noise that must be ignored, and every saturation edge is hit.
        queue_request(MODE_TICK, 0, 0);
        queue_request(MODE_SET_BOTH, 1, 1);
        queue_request(MODE_TICK, -1, -1);
        repeat (5) queue_request(MODE_TICK, 0, 0);
        queue_request(MODE_SET_SPEED, -1, 127);
        queue_request(MODE_TICK, 0, 0);
        queue_request(MODE_SET_STEER, 32767, -128);
        queue_request(MODE_TICK, 0, 0);
        queue_request(MODE_SET_BOTH, 32767, 127);
        queue_request(MODE_TICK, 0, 0);
        queue_request(MODE_SET_BOTH, -32768, -128);
        queue_request(MODE_TICK, 0, 0);
        queue_request(MODE_SET_SPEED, SPEED_LIMIT + 1, 0);
        queue_request(MODE_SET_SPEED, -SPEED_LIMIT - 1, 0);
        queue_request(MODE_SET_SPEED, SPEED_LIMIT, 0);
        queue_request(MODE_SET_STEER, 0, STEER_LEFT_LIMIT + 1);
        queue_request(MODE_SET_STEER, 0, STEER_RIGHT_LIMIT - 1);
        queue_request(MODE_SET_STEER, 0, STEER_LEFT_LIMIT);
        queue_request(MODE_TICK, 32767, 127);
        queue_request(MODE_TICK, -32768, -128);
        wait_idle();

        // Random phases, each under its own step setting. The first ones use
        // the largest steps, zero steps and the smallest non-zero steps; the
        // bench waits for every frame between phases before the next write.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:       write_steps(65535, 65535, 6400, 6400);
                1:       write_steps(0, 0, 0, 0);
                2:       write_steps(1, 1, 1, 1);
                default: write_steps(random_step(65535), random_step(65535),
                                     random_step(6400), random_step(6400));
            endcase
            if (phase == 3)
            begin
                // Back-to-back requests against a long receiver stall, so that
                // the block fills and holds off its input.
                send_gap_max <= 0;
                recv_gap_max <= 0;
            end
            else
            begin
                send_gap_max <= $urandom_range(0, 1) ? MAX_GAP : 0;
                recv_gap_max <= $urandom_range(0, 1) ? MAX_GAP : 0;
            end
            @(posedge clk);
            repeat (PHASE_ITEMS) pending_requests.push_back(random_request());
            if (phase == 3)
                hold_asks <= hold_asks + 1;
            wait_idle();
        end

        $display("Run covered %0d requests with %0d ticks over %0d step settings.",
                 requests_sent, ticks_sent, settings_used);
        $display("Checked %0d drive frames, %0d mismatched, %0d left unanswered.",
                 frames_checked, error_count, expected_frames.size());
        if (error_count == 0 && expected_frames.size() == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial
    begin
        #(CLK_PERIOD * 400000);
        $display("Run timed out with %0d frames outstanding.", expected_frames.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ files.f @@
rtl/dcrf_pkg.sv
rtl/dcrf_ramp.sv
rtl/drive_command_ramp_framer.sv
bench/testbench.sv
